// ===== rtl/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared constants for the multi-key debouncer and its port checker.
// ----------------------------------------------------------------------------
package mkd_pkg;

	// Widths of the sample and result fields, and of the agreement counters
	localparam int FIELD_W = 7;
	localparam int CNT_W   = 8;

	// Stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// Bit positions of the result fields in the output tdata
	localparam int PRESS_LSB   = 0;
	localparam int RELEASE_LSB = FIELD_W;
	localparam int HELD_LSB    = 2 * FIELD_W;

	localparam logic [CNT_W-1:0] THRESH_RESET = 8'd5;

	typedef logic [FIELD_W-1:0] key_vec_t;
	typedef logic [CNT_W-1:0]   cnt_t;

endpackage

// ===== rtl/multi_key_debouncer.sv =====
// Path: an accepted sample waits in the input register, then moves into the result
//   register, from which it is offered on the output until the receiver takes it.
// Throughput: one sample per clock unless the output stalls; the per-key update
//   is a single pass of logic.
// Reset (arst_n low): stable, candidate and agreement counters clear, the
//   threshold returns to 5, both pipeline stages empty.
// ----------------------------------------------------------------------------
// multi_key_debouncer
// Counter-based debounce of up to NUM_KEYS keys with press/release edge
// reporting, one result per raw sample.
// ----------------------------------------------------------------------------
module multi_key_debouncer #(
	parameter int NUM_KEYS = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// threshold register write
	input  logic                            cfg_we,
	input  logic [mkd_pkg::CNT_W-1:0]       cfg_wdata,
	// raw sample requests
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [mkd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [6:0] raw_keys, [7] zero
	// debounced results
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [mkd_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [6:0] press_edges,
	                                                        // [13:7] release_edges,
	                                                        // [20:14] held_keys, [23:21] zero
);
	import mkd_pkg::*;

	// Threshold register
	cnt_t thresh_q;

	// Input stage: one raw sample waiting for the state update
	logic     vld_s1;
	key_vec_t raw_s1;

	// Per-key state
	logic [NUM_KEYS-1:0] stable_q;
	logic [NUM_KEYS-1:0] cand_q;
	cnt_t                cnt_q [NUM_KEYS];

	// Next state and edges from the sample in stage 1
	logic [NUM_KEYS-1:0] raw_w;
	logic [NUM_KEYS-1:0] stable_d;
	logic [NUM_KEYS-1:0] cand_d;
	cnt_t                cnt_d [NUM_KEYS];
	logic [NUM_KEYS-1:0] press_w;
	logic [NUM_KEYS-1:0] release_w;

	// Result register
	logic     vld_s2;
	key_vec_t press_s2;
	key_vec_t release_s2;
	key_vec_t held_s2;

	key_vec_t press_o;
	key_vec_t release_o;
	key_vec_t held_o;

	// Stage 1 moves into the result register when that slot is free or draining.
	// The key state commits on that same edge, so state and results stay in step.
	logic adv_s1;
	assign adv_s1        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			raw_s1 <= s_axis_tdata[FIELD_W-1:0];
		end
	end

	// Keys beyond the sample width always see a released input.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_raw
		if (k < FIELD_W) begin : g_in
			assign raw_w[k] = raw_s1[k];
		end else begin : g_zero
			assign raw_w[k] = 1'b0;
		end
	end

	// Independent debouncer per key
	always_comb begin
		cnt_t c;
		c         = '0;
		stable_d  = stable_q;
		cand_d    = cand_q;
		press_w   = '0;
		release_w = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			cnt_d[k] = cnt_q[k];
			if (raw_w[k] == stable_q[k]) begin
				// agrees with stable state: nothing pending
				cnt_d[k]  = '0;
				cand_d[k] = raw_w[k];
			end else if (raw_w[k] != cand_q[k]) begin
				// new candidate: restart count, never flips on this sample
				cand_d[k] = raw_w[k];
				cnt_d[k]  = cnt_t'(1);
			end else begin
				c = cnt_q[k];
				if (c < thresh_q) begin
					c = c + cnt_t'(1);
				end
				if (c < thresh_q) begin
					cnt_d[k] = c;
				end else begin
					cnt_d[k]    = '0;
					stable_d[k] = raw_w[k];
					press_w[k]   = raw_w[k];
					release_w[k] = !raw_w[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			cand_q   <= '0;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (adv_s1) begin
			stable_q <= stable_d;
			cand_q   <= cand_d;
			for (int k = 0; k < NUM_KEYS; k++) begin
				cnt_q[k] <= cnt_d[k];
			end
		end
	end

	// Map keys onto the fixed-width result fields; higher keys drop out.
	for (genvar b = 0; b < FIELD_W; b++) begin : g_out
		if (b < NUM_KEYS) begin : g_key
			assign press_o[b]   = press_w[b];
			assign release_o[b] = release_w[b];
			assign held_o[b]    = stable_d[b];
		end else begin : g_none
			assign press_o[b]   = 1'b0;
			assign release_o[b] = 1'b0;
			assign held_o[b]    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			press_s2   <= press_o;
			release_s2 <= release_o;
			held_s2    <= held_o;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {(OUT_TDATA_W - 3*FIELD_W)'(0), held_s2, release_s2, press_s2};

endmodule

// ===== rtl/mkd_checker.sv =====
// ----------------------------------------------------------------------------
// mkd_checker
// Port-level checks of the debouncer's result stream.
// ----------------------------------------------------------------------------
module mkd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mkd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import mkd_pkg::*;

	key_vec_t press_w;
	key_vec_t release_w;
	key_vec_t held_w;

	assign press_w   = m_axis_tdata[PRESS_LSB +: FIELD_W];
	assign release_w = m_axis_tdata[RELEASE_LSB +: FIELD_W];
	assign held_w    = m_axis_tdata[HELD_LSB +: FIELD_W];

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a key cannot both press and release on one sample
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (press_w & release_w) == '0)
		else $error("press and release on same key");

	// a press leaves the key held
	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (press_w & ~held_w) == '0)
		else $error("pressed key not held");

	// a release leaves the key not held
	a_release_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (release_w & held_w) == '0)
		else $error("released key still held");

endmodule

bind multi_key_debouncer mkd_checker u_mkd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
